@@ hdl/urbe_pkg.sv @@
// ----------------------------------------------------------------------------
// urbe_pkg
// Shared types, codes and constants of the serial port ring buffer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package urbe_pkg;

    // Widths fixed by the item format.
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned MARK_W  = 2;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // Default buffer depths.
    localparam int unsigned RX_DEPTH_DEFAULT = 128;
    localparam int unsigned TX_DEPTH_DEFAULT = 2;

    // Marker reset values: '<' ends a QR frame, '$' ends a barcode frame.
    localparam logic [DATA_W-1:0] QR_MARKER_RESET      = 8'd60;
    localparam logic [DATA_W-1:0] BARCODE_MARKER_RESET = 8'd36;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QR_MARKER      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BARCODE_MARKER = 1'd1;

    // Frame mark codes.
    localparam logic [MARK_W-1:0] MARK_NONE    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_QR      = 2'd1;
    localparam logic [MARK_W-1:0] MARK_BARCODE = 2'd2;

    // Operation codes; the remaining codes have no effect.
    typedef enum logic [OP_W-1:0] {
        OP_RX_BYTE = 3'd0,
        OP_TX_DONE = 3'd1,
        OP_PUT     = 3'd2,
        OP_GET     = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    // Status that a queue reports to the control logic.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               empty;
        logic               full;
    } queue_status_t;

endpackage : urbe_pkg

`default_nettype wire

@@ hdl/uart_ring_buffer_engine_unit.sv @@
// ----------------------------------------------------------------------------
// uart_ring_buffer_engine_unit
// Receive and transmit ring buffers of a serial port with frame marker
// detection, a transmitter idle flag and a registered result beat.
// ----------------------------------------------------------------------------
// Each input beat is one event (line byte, transmit done, put, get or clear)
// and yields exactly one result beat in the cycle after. A new beat is taken in
// every cycle while the result register is empty or being drained, so the
// sustained rate is one item per clock; it is set by the single registered
// read port of each buffer memory, which is read at the accepting edge.
// The buffers need no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_ring_buffer_engine_unit
    import urbe_pkg::*;
#(
    parameter int unsigned RX_DEPTH = RX_DEPTH_DEFAULT,
    parameter int unsigned TX_DEPTH = TX_DEPTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_wdata,
    // Input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [DATA_W-1:0]    s_data_byte,
    // Result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [DATA_W-1:0]         m_read_data,
    output logic                      m_read_valid,
    output logic                      m_put_accepted,
    output logic [DATA_W-1:0]         m_line_byte,
    output logic                      m_line_send,
    output logic [LEVEL_W-1:0]        m_rx_level,
    output logic [LEVEL_W-1:0]        m_tx_level,
    output logic [MARK_W-1:0]         m_frame_mark,
    output logic                      m_rx_dropped
);

    localparam logic [LEVEL_W-1:0] RX_FULL_LEVEL = LEVEL_W'(RX_DEPTH);

    logic [DATA_W-1:0] qr_marker_reg;
    logic [DATA_W-1:0] barcode_marker_reg;
    logic              tx_idle_reg, tx_idle_next;
    logic              m_valid_reg;
    logic              read_valid_reg, read_valid_next;
    logic              put_accepted_reg, put_accepted_next;
    logic              line_send_reg, line_send_next;
    logic [MARK_W-1:0] frame_mark_reg, frame_mark_next;
    logic              rx_dropped_reg, rx_dropped_next;

    logic              accept;
    op_t               op;
    logic              rx_push, rx_pop, tx_push, tx_pop, queue_clear;
    logic [DATA_W-1:0] rx_pop_data, tx_pop_data;
    queue_status_t     rx_status, tx_status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = op_t'(s_operation);

    // Marker registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qr_marker_reg      <= QR_MARKER_RESET;
            barcode_marker_reg <= BARCODE_MARKER_RESET;
        end else if (cfg_wr_en) begin
            priority if (cfg_index == CFG_QR_MARKER) begin
                qr_marker_reg <= cfg_wdata;
            end else if (cfg_index == CFG_BARCODE_MARKER) begin
                barcode_marker_reg <= cfg_wdata;
            end
        end
    end

    // Event decode: queue strobes, flags and the transmitter idle flag.
    always_comb begin
        rx_push           = 1'b0;
        rx_pop            = 1'b0;
        tx_push           = 1'b0;
        tx_pop            = 1'b0;
        queue_clear       = 1'b0;
        read_valid_next   = 1'b0;
        put_accepted_next = 1'b0;
        line_send_next    = 1'b0;
        frame_mark_next   = MARK_NONE;
        rx_dropped_next   = 1'b0;
        tx_idle_next      = tx_idle_reg;
        if (accept) begin
            unique case (op)
                OP_RX_BYTE: begin
                    rx_push         = !rx_status.full;
                    rx_dropped_next = rx_status.full;
                    if (s_data_byte == barcode_marker_reg) begin
                        frame_mark_next = MARK_BARCODE;
                    end else if (s_data_byte == qr_marker_reg) begin
                        frame_mark_next = MARK_QR;
                    end
                end
                OP_TX_DONE: begin
                    tx_pop         = !tx_status.empty;
                    line_send_next = !tx_status.empty;
                    tx_idle_next   = tx_status.empty;
                end
                OP_PUT: begin
                    tx_push           = !tx_status.full;
                    put_accepted_next = !tx_status.full;
                    // An idle transmitter starts at once on a stored byte.
                    if (!tx_status.full && tx_idle_reg) begin
                        tx_pop         = 1'b1;
                        line_send_next = 1'b1;
                        tx_idle_next   = 1'b0;
                    end
                end
                OP_GET: begin
                    rx_pop          = !rx_status.empty;
                    read_valid_next = !rx_status.empty;
                end
                OP_CLEAR: begin
                    queue_clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Receive buffer.
    urbe_queue #(
        .DEPTH (RX_DEPTH)
    ) u_rx_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (rx_push),
        .push_data (s_data_byte),
        .pop_en    (rx_pop),
        .clear     (queue_clear),
        .pop_data  (rx_pop_data),
        .status    (rx_status)
    );

    // Transmit buffer.
    urbe_queue #(
        .DEPTH (TX_DEPTH)
    ) u_tx_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (tx_push),
        .push_data (s_data_byte),
        .pop_en    (tx_pop),
        .clear     (queue_clear),
        .pop_data  (tx_pop_data),
        .status    (tx_status)
    );

    // Control state: transmitter idle flag and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_idle_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            tx_idle_reg <= tx_idle_next;
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    // Result flags, loaded with each accepted beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            read_valid_reg   <= read_valid_next;
            put_accepted_reg <= put_accepted_next;
            line_send_reg    <= line_send_next;
            frame_mark_reg   <= frame_mark_next;
            rx_dropped_reg   <= rx_dropped_next;
        end
    end

    // Result beat; the levels follow the counts, which only move on acceptance.
    assign m_valid        = m_valid_reg;
    assign m_read_valid   = read_valid_reg;
    assign m_read_data    = read_valid_reg ? rx_pop_data : '0;
    assign m_put_accepted = put_accepted_reg;
    assign m_line_send    = line_send_reg;
    assign m_line_byte    = line_send_reg ? tx_pop_data : '0;
    assign m_rx_level     = rx_status.level;
    assign m_tx_level     = tx_status.level;
    assign m_frame_mark   = frame_mark_reg;
    assign m_rx_dropped   = rx_dropped_reg;

`ifndef NO_ASSERTIONS
    // A byte just handed to the transmitter leaves it busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_send |-> !tx_idle_reg)
        else $error("transmitter idle after a send");

    // A dropped line byte is reported only with a full receive buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_dropped |-> m_rx_level == RX_FULL_LEVEL)
        else $error("drop reported with room in the receive buffer");

    // A put refused on a full transmit buffer is reported as refused.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_PUT && tx_status.full |=> !m_put_accepted && !m_line_send)
        else $error("put to a full transmit buffer was taken");

    // The input side stalls only behind a result that is held back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // A get on a non-empty buffer lowers the receive level by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_GET && !rx_status.empty |=>
            m_read_valid && m_rx_level == $past(rx_status.level) - 1'b1)
        else $error("get did not consume a received byte");
`endif

endmodule : uart_ring_buffer_engine_unit

`default_nettype wire

@@ hdl/urbe_queue.sv @@
// ----------------------------------------------------------------------------
// urbe_queue
// Ring buffer with a memory, wrap-around write and read counts, a registered
// read port and a bypass for a pop of a byte pushed into an empty queue.
// ----------------------------------------------------------------------------
`default_nettype none

module urbe_queue
    import urbe_pkg::*;
#(
    parameter int unsigned DEPTH = RX_DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_en,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop_en,
    input  wire logic              clear,
    output logic      [DATA_W-1:0] pop_data,
    output queue_status_t          status
);

    // Counts run modulo twice the depth so that full and empty differ.
    localparam int unsigned CW = $clog2(2 * DEPTH);
    localparam int unsigned SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW:0] DEPTH_W    = (CW + 1)'(DEPTH);
    localparam logic [CW:0] TWO_DEPTH  = (CW + 1)'(2 * DEPTH);
    localparam logic [CW-1:0] LAST_CNT = CW'(2 * DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] pop_data_reg;
    logic [CW-1:0]     wr_cnt_reg, wr_cnt_next;
    logic [CW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [CW:0]       level;
    logic [SW-1:0]     wr_slot;
    logic [SW-1:0]     rd_slot;
    logic              bypass;

    // Fill level and slot numbers from the counts.
    always_comb begin
        if (wr_cnt_reg >= rd_cnt_reg) begin
            level = {1'b0, wr_cnt_reg} - {1'b0, rd_cnt_reg};
        end else begin
            level = {1'b0, wr_cnt_reg} + TWO_DEPTH - {1'b0, rd_cnt_reg};
        end
        if ({1'b0, wr_cnt_reg} >= DEPTH_W) begin
            wr_slot = SW'({1'b0, wr_cnt_reg} - DEPTH_W);
        end else begin
            wr_slot = SW'(wr_cnt_reg);
        end
        if ({1'b0, rd_cnt_reg} >= DEPTH_W) begin
            rd_slot = SW'({1'b0, rd_cnt_reg} - DEPTH_W);
        end else begin
            rd_slot = SW'(rd_cnt_reg);
        end
    end

    assign status.level = LEVEL_W'(level);
    assign status.empty = (level == '0);
    assign status.full  = (level == DEPTH_W);

    // A pop from an empty queue in the same beat as a push returns the new byte.
    assign bypass = push_en && pop_en && status.empty;

    // Next counts, with wrap and clear.
    always_comb begin
        wr_cnt_next = wr_cnt_reg;
        rd_cnt_next = rd_cnt_reg;
        if (clear) begin
            wr_cnt_next = '0;
            rd_cnt_next = '0;
        end else begin
            if (push_en) begin
                wr_cnt_next = (wr_cnt_reg == LAST_CNT) ? '0 : wr_cnt_reg + 1'b1;
            end
            if (pop_en) begin
                rd_cnt_next = (rd_cnt_reg == LAST_CNT) ? '0 : rd_cnt_reg + 1'b1;
            end
        end
    end

    // Count registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_cnt_reg <= '0;
            rd_cnt_reg <= '0;
        end else begin
            wr_cnt_reg <= wr_cnt_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // Memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[wr_slot] <= push_data;
        end
        if (pop_en) begin
            pop_data_reg <= bypass ? push_data : mem[rd_slot];
        end
    end

    assign pop_data = pop_data_reg;

endmodule : urbe_queue

`default_nettype wire
